// ===== sv/ecti_pkg.sv =====
`default_nettype none

package ecti_pkg;

  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned TAPE_DEPTH = 32768;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned PA_W = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W = PA_W + 1;
  localparam int unsigned PTR_W = $clog2(TAPE_DEPTH);
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_PRINT = 8'h2E;
  localparam logic [7:0] CH_READ  = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic [1:0] STATUS_RUN       = 2'd0;
  localparam logic [1:0] STATUS_END       = 2'd1;
  localparam logic [1:0] STATUS_UNMATCHED = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef enum logic {
    ITEM_LOAD = 1'b0,
    ITEM_STEP = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    SCAN_NONE = 2'd0,
    SCAN_FWD  = 2'd1,
    SCAN_BACK = 2'd2
  } scan_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
    logic       in_ok;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/ecti_front.sv =====
`default_nettype none

module ecti_front
  import ecti_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       mode_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       input_valid_i,
  input  wire logic       clear_busy_i,
  output logic            deq_valid_o,
  input  wire logic       deq_ready_i,
  output item_t           deq_item_o
);

  item_t             queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;
  item_t             new_item;

  assign in_ready_o  = (count_q < QCNT_W'(QUEUE_DEPTH)) && !clear_busy_i;
  assign deq_valid_o = (count_q != '0);
  assign deq_item_o  = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = deq_valid_o && deq_ready_i;

  always_comb begin
    new_item.kind  = mode_i ? ITEM_STEP : ITEM_LOAD;
    new_item.data  = data_byte_i;
    new_item.in_ok = input_valid_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ecti_back.sv =====
`default_nettype none

module ecti_back
  import ecti_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       deq_valid_i,
  output logic            deq_ready_o,
  input  wire item_t      deq_item_i,
  output logic            clear_busy_o,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            waiting_input_o,
  output logic [1:0]      status_o
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  logic [7:0]       prog_mem [PROG_DEPTH];
  logic [7:0]       tape_mem [TAPE_DEPTH];
  logic [7:0]       ch_q, cell_q;

  state_e           state_q, state_d;
  logic [PC_W-1:0]  len_q, len_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [PTR_W-1:0] clr_q, clr_d;
  scan_e            scan_q, scan_d;
  logic [PC_W-1:0]  depth_q, depth_d;
  logic [1:0]       fault_q, fault_d;
  item_t            item_q, item_d;
  logic             res_valid_q, res_valid_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             waiting_q, waiting_d;
  logic [1:0]       status_q, status_d;

  logic             slot_free;
  logic             prog_we;
  logic             tape_we;
  logic [PTR_W-1:0] tape_waddr;
  logic [7:0]       tape_wdata;
  logic             rd_en;
  logic [PTR_W:0]   ptr_inc;

  assign slot_free       = !res_valid_q || res_ready_i;
  assign clear_busy_o    = (state_q == ST_CLEAR);
  assign res_valid_o     = res_valid_q;
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign waiting_input_o = waiting_q;
  assign status_o        = status_q;
  assign ptr_inc         = {1'b0, ptr_q} + 1'b1;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pc_d        = pc_q;
    ptr_d       = ptr_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    depth_d     = depth_q;
    fault_d     = fault_q;
    item_d      = item_q;
    res_valid_d = res_valid_q && !res_ready_i;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    waiting_d   = waiting_q;
    status_d    = status_q;
    prog_we     = 1'b0;
    tape_we     = 1'b0;
    tape_waddr  = ptr_q;
    tape_wdata  = cell_q;
    rd_en       = 1'b0;
    deq_ready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        tape_wdata = '0;
        if (clr_q == PTR_W'(TAPE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        deq_ready_o = slot_free;
        if (deq_valid_i && slot_free) begin
          if (deq_item_i.kind == ITEM_LOAD) begin
            if (len_q < PC_W'(PROG_DEPTH)) begin
              prog_we = 1'b1;
              len_d   = len_q + 1'b1;
            end else begin
              fault_d = STATUS_FULL;
            end
            res_valid_d = 1'b1;
            out_valid_d = 1'b0;
            out_byte_d  = '0;
            waiting_d   = 1'b0;
            status_d    = fault_d;
          end else begin
            item_d  = deq_item_i;
            rd_en   = 1'b1;
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          out_valid_d = 1'b0;
          out_byte_d  = '0;
          waiting_d   = 1'b0;
          if (fault_q == STATUS_RUN) begin
            if (scan_q != SCAN_NONE) begin
              if (pc_q >= len_q) begin
                fault_d = STATUS_UNMATCHED;
                scan_d  = SCAN_NONE;
              end else if (scan_q == SCAN_FWD) begin
                depth_d = depth_q + PC_W'(ch_q == CH_OPEN) - PC_W'(ch_q == CH_CLOSE);
                pc_d    = pc_q + 1'b1;
                if (depth_d == '0) begin
                  scan_d = SCAN_NONE;
                end
              end else begin
                depth_d = depth_q + PC_W'(ch_q == CH_CLOSE) - PC_W'(ch_q == CH_OPEN);
                if (depth_d == '0) begin
                  pc_d   = pc_q + 1'b1;
                  scan_d = SCAN_NONE;
                end else if (pc_q == '0) begin
                  fault_d = STATUS_UNMATCHED;
                  scan_d  = SCAN_NONE;
                end else begin
                  pc_d = pc_q - 1'b1;
                end
              end
            end else if (pc_q < len_q) begin
              pc_d = pc_q + 1'b1;
              unique case (ch_q)
                CH_RIGHT: begin
                  ptr_d = (ptr_inc >= (PTR_W + 1)'(TAPE_DEPTH)) ? '0 : ptr_inc[PTR_W-1:0];
                end
                CH_LEFT: begin
                  ptr_d = (ptr_q == '0) ? PTR_W'(TAPE_DEPTH - 1) : ptr_q - 1'b1;
                end
                CH_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_q + 8'd1;
                end
                CH_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_q - 8'd1;
                end
                CH_PRINT: begin
                  out_valid_d = 1'b1;
                  out_byte_d  = cell_q;
                end
                CH_READ: begin
                  if (item_q.in_ok) begin
                    tape_we    = 1'b1;
                    tape_wdata = item_q.data;
                  end else begin
                    waiting_d = 1'b1;
                    pc_d      = pc_q;
                  end
                end
                CH_OPEN: begin
                  if (cell_q == '0) begin
                    scan_d  = SCAN_FWD;
                    depth_d = PC_W'(1);
                  end
                end
                CH_CLOSE: begin
                  if (cell_q != '0) begin
                    if (pc_q == '0) begin
                      fault_d = STATUS_UNMATCHED;
                      pc_d    = pc_q;
                    end else begin
                      scan_d  = SCAN_BACK;
                      depth_d = PC_W'(1);
                      pc_d    = pc_q - 1'b1;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
          end
          if (fault_d != STATUS_RUN) begin
            status_d = fault_d;
          end else if (scan_d == SCAN_NONE && pc_d >= len_q) begin
            status_d = STATUS_END;
          end else begin
            status_d = STATUS_RUN;
          end
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      len_q       <= '0;
      pc_q        <= '0;
      ptr_q       <= '0;
      clr_q       <= '0;
      scan_q      <= SCAN_NONE;
      depth_q     <= '0;
      fault_q     <= STATUS_RUN;
      item_q      <= '0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      waiting_q   <= 1'b0;
      status_q    <= STATUS_RUN;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pc_q        <= pc_d;
      ptr_q       <= ptr_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      depth_q     <= depth_d;
      fault_q     <= fault_d;
      item_q      <= item_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      waiting_q   <= waiting_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[len_q[PA_W-1:0]] <= deq_item_i.data;
    end
    if (rd_en) begin
      ch_q <= prog_mem[pc_q[PA_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    if (rd_en) begin
      cell_q <= tape_mem[ptr_q];
    end
  end

endmodule

`default_nettype wire

// ===== sv/eight_command_tape_interpreter.sv =====
// Eight-command tape interpreter with a program store and a byte tape.
// The input channel (in_valid_i / in_ready_o) carries one word per item:
// mode_i 0 appends data_byte_i to the program, mode_i 1 executes one step,
// with data_byte_i and input_valid_i offering a byte to the read command.
// The result channel (res_valid_o / res_ready_i) returns exactly one word
// per item: the printed byte, the input wait flag and the run status.
// Accepted words enter a two-word queue; the execution unit takes them
// in order. A load word yields its result at the edge where it leaves the
// queue, and a step word in the cycle after that, since a step reads the
// program store and the tape from synchronous memory and then writes the
// tape back. Sustained throughput is one load per cycle while the receiver
// takes each result; a step holds the execution unit in its execute state,
// so the next word waits until the step's result is out. After reset the
// tape is cleared one cell per cycle, and no word is accepted during that
// pass. A result waits in the output register while the receiver stalls;
// the queue keeps accepting words until it is full.
`default_nettype none

module eight_command_tape_interpreter
  import ecti_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       mode_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       input_valid_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            waiting_input_o,
  output logic [1:0]      status_o
);

  logic  clear_busy;
  logic  deq_valid;
  logic  deq_ready;
  item_t deq_item;

  ecti_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .input_valid_i(input_valid_i),
    .clear_busy_i (clear_busy),
    .deq_valid_o  (deq_valid),
    .deq_ready_i  (deq_ready),
    .deq_item_o   (deq_item)
  );

  ecti_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .deq_valid_i    (deq_valid),
    .deq_ready_o    (deq_ready),
    .deq_item_i     (deq_item),
    .clear_busy_o   (clear_busy),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .waiting_input_o(waiting_input_o),
    .status_o       (status_o)
  );

  // No word may enter while the tape is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !in_ready_o)
    else $error("input accepted during tape clear");

  // No result appears until the tape clear has finished.
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !res_valid_o)
    else $error("result produced during tape clear");

  // A step never both prints and waits for input.
  a_print_or_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(out_valid_o && waiting_input_o))
    else $error("print and input wait in one result");

  // A faulted result never carries printed data or an input wait.
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (status_o == STATUS_UNMATCHED || status_o == STATUS_FULL))
      |-> (!out_valid_o && !waiting_input_o))
    else $error("fault result with print or wait");

endmodule

`default_nettype wire
